@@ hw/rtl/snrt_pkg.sv @@
package snrt_pkg;

	// Table geometry
	localparam int TBL_N = 32;
	localparam int IDX_W = $clog2(TBL_N);
	localparam int CNT_W = $clog2(TBL_N + 1);
	localparam int ENT_W = 40;
	localparam int DIV_W = 6;

	localparam logic [CNT_W-1:0] TBL_CNT  = CNT_W'(TBL_N);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_N - 1);
	localparam logic [CNT_W:0]   ROOM_MAX = (CNT_W + 1)'(TBL_N - 1);

	// Action codes
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_UPD_NB  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_NB  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INS_RT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FIND_NB = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND_RT = 3'd4;

	// Register file
	localparam int ADDR_W = 5;
	localparam int REG_W  = 3;
	localparam logic [REG_W-1:0] REG_DIVISION  = 3'd0;
	localparam logic [REG_W-1:0] REG_QUPD_EN   = 3'd1;
	localparam logic [REG_W-1:0] REG_MASKED_Q  = 3'd2;
	localparam logic [REG_W-1:0] REG_PERFECT_Q = 3'd3;
	localparam logic [REG_W-1:0] REG_MAX_Q     = 3'd4;
	localparam logic [REG_W-1:0] REG_MIN_Q     = 3'd5;
	localparam logic [REG_W-1:0] REG_RADIO_ANY = 3'd6;

	typedef struct packed {
		logic [DIV_W-1:0] division;
		logic             qupd_en;
		logic [7:0]       masked_q;
		logic [7:0]       perfect_q;
		logic [7:0]       max_q;
		logic [7:0]       min_q;
		logic [7:0]       radio_any;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MD_NB,
		MD_RT,
		MD_VIA
	} scan_mode_t;

	typedef struct packed {
		logic             load;
		logic             issue;
		logic [IDX_W-1:0] addr;
		logic             route_mode;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [CNT_W-1:0] nc;
		logic [CNT_W-1:0] rc;
		logic [IDX_W-1:0] via;
	} sts_t;

endpackage

@@ hw/rtl/snrt_regs.sv @@
module snrt_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [snrt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output snrt_pkg::cfg_t              cfg
);

	snrt_pkg::cfg_t cfg_q;
	logic [snrt_pkg::REG_W-1:0] idx;
	logic wr;

	assign idx    = paddr[snrt_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.division  <= snrt_pkg::DIV_W'(16);
			cfg_q.qupd_en   <= 1'b1;
			cfg_q.masked_q  <= 8'd0;
			cfg_q.perfect_q <= 8'd255;
			cfg_q.max_q     <= 8'd254;
			cfg_q.min_q     <= 8'd1;
			cfg_q.radio_any <= 8'd255;
		end else if (wr) begin
			case (idx)
				snrt_pkg::REG_DIVISION:  cfg_q.division  <= pwdata[snrt_pkg::DIV_W-1:0];
				snrt_pkg::REG_QUPD_EN:   cfg_q.qupd_en   <= pwdata[0];
				snrt_pkg::REG_MASKED_Q:  cfg_q.masked_q  <= pwdata[7:0];
				snrt_pkg::REG_PERFECT_Q: cfg_q.perfect_q <= pwdata[7:0];
				snrt_pkg::REG_MAX_Q:     cfg_q.max_q     <= pwdata[7:0];
				snrt_pkg::REG_MIN_Q:     cfg_q.min_q     <= pwdata[7:0];
				snrt_pkg::REG_RADIO_ANY: cfg_q.radio_any <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			snrt_pkg::REG_DIVISION:  prdata = 32'(cfg_q.division);
			snrt_pkg::REG_QUPD_EN:   prdata = 32'(cfg_q.qupd_en);
			snrt_pkg::REG_MASKED_Q:  prdata = 32'(cfg_q.masked_q);
			snrt_pkg::REG_PERFECT_Q: prdata = 32'(cfg_q.perfect_q);
			snrt_pkg::REG_MAX_Q:     prdata = 32'(cfg_q.max_q);
			snrt_pkg::REG_MIN_Q:     prdata = 32'(cfg_q.min_q);
			snrt_pkg::REG_RADIO_ANY: prdata = 32'(cfg_q.radio_any);
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

@@ hw/rtl/snrt_ctrl.sv @@
module snrt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  snrt_pkg::sts_t sts,
	output snrt_pkg::cmd_t cmd
);

	snrt_pkg::ctrl_state_t state_q, state_d;
	snrt_pkg::scan_mode_t  md_q, md_d;
	logic [snrt_pkg::CNT_W-1:0] cnt_q, cnt_d, lim_q, lim_d, cnt_nx;
	logic out_valid_q, out_valid_d;

	assign in_ready  = (state_q == snrt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign cnt_nx    = cnt_q + snrt_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= snrt_pkg::ST_IDLE;
			md_q        <= snrt_pkg::MD_NB;
			cnt_q       <= '0;
			lim_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			md_q        <= md_d;
			cnt_q       <= cnt_d;
			lim_q       <= lim_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		md_d        = md_q;
		cnt_d       = cnt_q;
		lim_d       = lim_q;
		cmd.load    = 1'b0;
		cmd.issue   = 1'b0;
		cmd.finish  = 1'b0;
		out_valid_d = out_valid_q && !out_ready;

		case (md_q)
			snrt_pkg::MD_NB:  cmd.addr = cnt_q[snrt_pkg::IDX_W-1:0];
			snrt_pkg::MD_RT:  cmd.addr = snrt_pkg::LAST_IDX - cnt_q[snrt_pkg::IDX_W-1:0];
			snrt_pkg::MD_VIA: cmd.addr = sts.via;
			default:          cmd.addr = '0;
		endcase
		cmd.route_mode = (md_q == snrt_pkg::MD_RT);

		case (state_q)
			snrt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = snrt_pkg::ST_START;
				end
			end
			snrt_pkg::ST_START: begin
				cnt_d = '0;
				case (sts.act)
					snrt_pkg::ACT_UPD_NB, snrt_pkg::ACT_FIND_NB: begin
						md_d  = snrt_pkg::MD_NB;
						lim_d = sts.nc;
					end
					snrt_pkg::ACT_FIND_RT: begin
						md_d  = snrt_pkg::MD_RT;
						lim_d = sts.rc;
					end
					snrt_pkg::ACT_INS_RT: begin
						md_d  = snrt_pkg::MD_VIA;
						lim_d = snrt_pkg::CNT_W'(1);
					end
					default: begin
						md_d  = snrt_pkg::MD_NB;
						lim_d = '0;
					end
				endcase
				state_d = (lim_d == '0) ? snrt_pkg::ST_DONE : snrt_pkg::ST_SCAN;
			end
			snrt_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				cnt_d     = cnt_nx;
				if (cnt_nx == lim_q) state_d = snrt_pkg::ST_DRAIN1;
			end
			snrt_pkg::ST_DRAIN1: state_d = snrt_pkg::ST_DRAIN2;
			snrt_pkg::ST_DRAIN2: state_d = snrt_pkg::ST_DONE;
			snrt_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = snrt_pkg::ST_IDLE;
				end
			end
			default: state_d = snrt_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/snrt_dp.sv @@
module snrt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  snrt_pkg::cfg_t             cfg,
	input  snrt_pkg::cmd_t             cmd,
	input  logic [snrt_pkg::ACT_W-1:0] action,
	input  logic [15:0]                node_id,
	input  logic [7:0]                 link_quality,
	input  logic [7:0]                 radio_sel,
	input  logic [7:0]                 net_id,
	input  logic [snrt_pkg::IDX_W-1:0] via_index,
	input  logic                       include_hidden,
	output snrt_pkg::sts_t             sts,
	output logic                       ok,
	output logic [snrt_pkg::IDX_W-1:0] hit_index,
	output logic [snrt_pkg::CNT_W-1:0] neighbor_total,
	output logic [snrt_pkg::CNT_W-1:0] route_total
);

	localparam int IW = snrt_pkg::IDX_W;
	localparam int CW = snrt_pkg::CNT_W;
	localparam int EW = snrt_pkg::ENT_W;

	// item registers
	logic [snrt_pkg::ACT_W-1:0] act_q;
	logic [15:0] id_q;
	logic [7:0]  lq_q, rad_q, net_q;
	logic [IW-1:0] via_q;
	logic hid_q;

	logic [CW-1:0] nc_q, rc_q, nc_d, rc_d;

	// table with per-entry valid bits
	logic [EW-1:0] mem_q [snrt_pkg::TBL_N];
	logic [snrt_pkg::TBL_N-1:0] vld_q;

	// scan pipeline
	logic [EW-1:0] rda_s1, rdb_s2;
	logic [IW-1:0] slot_s1, slot_s2, rdb_addr;
	logic v_s1, v_s2, idm_s2;

	// best candidate
	logic found_q, idm_q;
	logic [IW-1:0] best_idx_q;
	logic [7:0] bestq_q;
	logic [EW-1:0] bent_q;

	logic [7:0] nb_q, nb_rad, nq;
	logic hid_eff, pass, take;
	logic nb_room, rt_room, via_ok, ins_nb;
	logic wr_en;
	logic [IW-1:0] wr_addr, slot_rt, res_hit, hit_q;
	logic [EW-1:0] wr_data;
	logic res_ok, ok_q;
	logic [CW-1:0] nt_q, rt_q;

	assign sts.act = act_q;
	assign sts.nc  = nc_q;
	assign sts.rc  = rc_q;
	assign sts.via = via_q;

	assign ok             = ok_q;
	assign hit_index      = hit_q;
	assign neighbor_total = nt_q;
	assign route_total    = rt_q;

	// route scan follows the next-hop field, neighbor scan rereads its own slot
	assign rdb_addr = cmd.route_mode ? rda_s1[16 +: IW] : slot_s1;

	assign nb_q    = rdb_s2[23:16];
	assign nb_rad  = rdb_s2[31:24];
	assign hid_eff = hid_q && (act_q == snrt_pkg::ACT_FIND_NB || act_q == snrt_pkg::ACT_FIND_RT);
	assign pass    = v_s2 && idm_s2 && (rad_q == cfg.radio_any || nb_rad == rad_q)
	                 && (hid_eff || nb_q != cfg.masked_q);
	assign take    = pass && (!found_q || nb_q > bestq_q);

	assign nb_room = (nc_q < cfg.division) && (nc_q < snrt_pkg::TBL_CNT);
	assign rt_room = ({1'b0, rc_q} + {1'b0, cfg.division}) <= snrt_pkg::ROOM_MAX;
	assign via_ok  = {{(CW-IW){1'b0}}, via_q} < nc_q;
	assign slot_rt = snrt_pkg::LAST_IDX - rc_q[IW-1:0];

	always_comb begin
		if (lq_q == cfg.perfect_q)     nq = cfg.max_q;
		else if (lq_q == cfg.masked_q) nq = cfg.min_q;
		else                           nq = lq_q;

		ins_nb  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = nc_q[IW-1:0];
		wr_data = {net_q, rad_q, lq_q, id_q};
		res_ok  = 1'b0;
		res_hit = '0;
		nc_d    = nc_q;
		rc_d    = rc_q;

		case (act_q)
			snrt_pkg::ACT_UPD_NB: begin
				if (found_q) begin
					res_hit = best_idx_q;
					if (cfg.qupd_en) begin
						wr_en   = 1'b1;
						wr_addr = best_idx_q;
						wr_data = {bent_q[EW-1:24], nq, bent_q[15:0]};
					end
				end else begin
					ins_nb = nb_room;
				end
			end
			snrt_pkg::ACT_INS_NB: ins_nb = nb_room;
			snrt_pkg::ACT_INS_RT: begin
				if (rt_room && via_ok && !idm_q) begin
					wr_en   = 1'b1;
					wr_addr = slot_rt;
					wr_data = {{(EW-16-IW){1'b0}}, via_q, id_q};
					res_ok  = 1'b1;
					res_hit = slot_rt;
					rc_d    = rc_q + CW'(1);
				end
			end
			snrt_pkg::ACT_FIND_NB, snrt_pkg::ACT_FIND_RT: begin
				res_ok  = found_q;
				res_hit = found_q ? best_idx_q : '0;
			end
			default: ;
		endcase

		if (ins_nb) begin
			wr_en   = 1'b1;
			res_ok  = 1'b1;
			res_hit = nc_q[IW-1:0];
			nc_d    = nc_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q    <= '0;
			rc_q    <= '0;
			vld_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.load)      found_q <= 1'b0;
			else if (take)     found_q <= 1'b1;
			if (cmd.finish) begin
				nc_q <= nc_d;
				rc_q <= rc_d;
				if (wr_en) vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rda_s1  <= vld_q[cmd.addr] ? mem_q[cmd.addr] : '0;
		slot_s1 <= cmd.addr;
		rdb_s2  <= vld_q[rdb_addr] ? mem_q[rdb_addr] : '0;
		slot_s2 <= slot_s1;
		idm_s2  <= (rda_s1[15:0] == id_q);
		if (cmd.finish && wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			id_q  <= node_id;
			lq_q  <= link_quality;
			rad_q <= radio_sel;
			net_q <= net_id;
			via_q <= via_index;
			hid_q <= include_hidden;
		end
		if (v_s2) idm_q <= idm_s2;
		if (take) begin
			best_idx_q <= slot_s2;
			bestq_q    <= nb_q;
			bent_q     <= rdb_s2;
		end
		if (cmd.finish) begin
			ok_q <= res_ok;
			hit_q <= res_hit;
			nt_q <= nc_d;
			rt_q <= rc_d;
		end
	end

endmodule

@@ hw/rtl/split_neighbor_route_table_core.sv @@
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------------
// in        in_valid / in_ready    action, node_id, link_quality, radio_sel,
//                                  net_id, via_index, include_hidden
// out       out_valid / out_ready  ok, hit_index, neighbor_total, route_total
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready (4-byte stride)
//
// One item at a time. A find or an update scans the neighbor or route area
// through the read pipeline, one entry per cycle. A neighbor insert, an
// unused code or a scan of an empty area goes from setup straight to the
// commit; a route insert does one read to check the next hop. The next beat
// is taken in the cycle after the commit.
// Reset clears the entry valid bits at once, so no clearing pass is needed.
// A stalled result beat stays in the output register while the next item is
// taken in; that item holds in its final state until the register frees up.
module split_neighbor_route_table_core (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [snrt_pkg::ACT_W-1:0]  action,
	input  logic [15:0]                 node_id,
	input  logic [7:0]                  link_quality,
	input  logic [7:0]                  radio_sel,
	input  logic [7:0]                  net_id,
	input  logic [snrt_pkg::IDX_W-1:0]  via_index,
	input  logic                        include_hidden,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic [snrt_pkg::IDX_W-1:0]  hit_index,
	output logic [snrt_pkg::CNT_W-1:0]  neighbor_total,
	output logic [snrt_pkg::CNT_W-1:0]  route_total,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [snrt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	snrt_pkg::cfg_t cfg;
	snrt_pkg::cmd_t cmd;
	snrt_pkg::sts_t sts;

	// Register file: division, quality remap values, radio wildcard.
	snrt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accept a beat, pick the scan area, step the index, drain the
	// read pipeline, then commit the result beat.
	snrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, scan pipeline, best-candidate tracking, counts and result beat.
	snrt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.action         (action),
		.node_id        (node_id),
		.link_quality   (link_quality),
		.radio_sel      (radio_sel),
		.net_id         (net_id),
		.via_index      (via_index),
		.include_hidden (include_hidden),
		.sts            (sts),
		.ok             (ok),
		.hit_index      (hit_index),
		.neighbor_total (neighbor_total),
		.route_total    (route_total)
	);

	// Commit only when the output register is free or draining this cycle.
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result committed over a pending beat");

	// Counts never pass the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.nc <= snrt_pkg::TBL_CNT) && (sts.rc <= snrt_pkg::TBL_CNT))
		else $error("entry count beyond table size");

	// One item at a time: an accepted beat closes the input side.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is at work");

	// Load is followed by the setup cycle, never by a read or a commit.
	a_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!cmd.issue && !cmd.finish))
		else $error("scan or commit right after load");

endmodule
